FILE: sv/next_permutation_engine_core_defines.svh
// Assertion macros shared by the checker of the next permutation engine.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef NEXT_PERMUTATION_ENGINE_CORE_DEFINES_SVH
`define NEXT_PERMUTATION_ENGINE_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define NPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("npe check failed");

// Consequent must hold in the same cycle as the antecedent.
`define NPE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("npe check failed");

`endif

FILE: sv/npe_pkg.sv
// Package of the next permutation engine: sizes, item types and sequencer states.
// No dependencies; the other files of the block that use it refer to it by scoped names.
package npe_pkg;

  localparam int unsigned MaxLen    = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrWidth = $clog2(MaxLen);
  localparam int unsigned CntWidth  = $clog2(MaxLen + 1);

  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic                        last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_value;
    logic                        last_out;
    logic                        wrapped;
    logic                        overflow;
  } out_item_t;

  // Result handed from the sequencer to the output stage.
  typedef struct packed {
    logic      load;
    out_item_t item;
  } emit_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_SW_RDA,
    ST_SW_RDB,
    ST_SW_WA,
    ST_SW_WB,
    ST_REV,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_e;

endpackage

FILE: sv/npe_if.sv
// Valid/ready stream interfaces for the input and result items of the engine.
// Depends on npe_pkg for the item types.
interface npe_in_if;
  logic             valid;
  logic             ready;
  npe_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface npe_out_if;
  logic               valid;
  logic               ready;
  npe_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/next_permutation_engine_core.sv
// Next lexicographic permutation engine. While the engine is loading, elements are
// taken one per cycle into a 16-entry element memory; at most 16 are kept and any
// further ones raise the overflow flag. The item carrying last_in starts the work,
// whose length is set by the memory's single read port: a pivot scan from the rightmost
// element, a search for the swap partner and the swap (both skipped when there is no
// pivot), the reversal one pair at a time, then the read-out of the first result.
// Each further input item after the final one releases the next element, which is
// read from the memory and loaded into the output register once that is free; the
// items themselves are ignored. The memory holds no reset contents and needs no
// clearing pass, so the block accepts items from the first cycle after reset.
// Depends on npe_pkg, npe_if, npe_ram, npe_seq and npe_out.
module next_permutation_engine_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  npe_in_if.sink    in_i,
  npe_out_if.source out_o
);

  npe_pkg::emit_t                emit;
  logic                          out_free;
  logic                          ram_we;
  logic [npe_pkg::AddrWidth-1:0] ram_waddr;
  logic [npe_pkg::DataWidth-1:0] ram_wdata;
  logic [npe_pkg::AddrWidth-1:0] ram_raddr;
  logic [npe_pkg::DataWidth-1:0] ram_rdata;

  npe_ram #(
    .WIDTH (npe_pkg::DataWidth),
    .DEPTH (npe_pkg::MaxLen)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  npe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data),
    .in_ready_o (in_i.ready),
    .out_free_i (out_free),
    .emit_o     (emit),
    .we_o       (ram_we),
    .waddr_o    (ram_waddr),
    .wdata_o    (ram_wdata),
    .raddr_o    (ram_raddr),
    .rdata_i    (ram_rdata)
  );

  npe_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .out_free_o  (out_free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

FILE: sv/npe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module npe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/npe_seq.sv
// Sequencer of the engine: loads elements, finds the pivot, swaps, reverses
// and reads results back, all through the element memory. Depends on npe_pkg.
module npe_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  npe_pkg::in_item_t                in_data_i,
  output logic                             in_ready_o,
  input  logic                             out_free_i,
  output npe_pkg::emit_t                   emit_o,
  output logic                             we_o,
  output logic [npe_pkg::AddrWidth-1:0]    waddr_o,
  output logic [npe_pkg::DataWidth-1:0]    wdata_o,
  output logic [npe_pkg::AddrWidth-1:0]    raddr_o,
  input  logic [npe_pkg::DataWidth-1:0]    rdata_i
);

  npe_pkg::state_e state_q, state_d;

  logic [npe_pkg::CntWidth-1:0]  fill_q, fill_d;
  logic                          ovf_q, ovf_d;
  logic                          wrap_q, wrap_d;
  logic                          have_right_q, have_right_d;
  logic [npe_pkg::AddrWidth-1:0] idx_q, idx_d;
  logic [npe_pkg::AddrWidth-1:0] piv_q, piv_d;
  logic [npe_pkg::AddrWidth-1:0] lo_q, lo_d;
  logic [npe_pkg::AddrWidth-1:0] hi_q, hi_d;
  logic [npe_pkg::AddrWidth-1:0] sa_q, sa_d;
  logic [npe_pkg::AddrWidth-1:0] sb_q, sb_d;
  logic [npe_pkg::AddrWidth-1:0] epos_q, epos_d;
  logic [npe_pkg::DataWidth-1:0] right_q, right_d;
  logic [npe_pkg::DataWidth-1:0] pivval_q, pivval_d;
  logic [npe_pkg::DataWidth-1:0] tmp_q, tmp_d;

  logic                          accept;
  logic                          scan_hit;
  logic                          find_hit;
  logic                          emit_last;
  logic [npe_pkg::AddrWidth-1:0] last_idx;
  logic [npe_pkg::CntWidth-1:0]  epos_next;

  assign accept    = in_valid_i && in_ready_o;
  assign last_idx  = npe_pkg::AddrWidth'(fill_q - 1'b1);
  assign scan_hit  = have_right_q && ($signed(rdata_i) < $signed(right_q));
  assign find_hit  = $signed(pivval_q) < $signed(rdata_i);
  assign epos_next = npe_pkg::CntWidth'(epos_q) + 1'b1;
  assign emit_last = epos_next >= fill_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      npe_pkg::ST_LOAD: begin
        if (accept && in_data_i.last_in) begin
          state_d = npe_pkg::ST_SCAN_RD;
        end
      end
      npe_pkg::ST_SCAN_RD:  state_d = npe_pkg::ST_SCAN_CMP;
      npe_pkg::ST_SCAN_CMP: begin
        if (scan_hit) begin
          state_d = npe_pkg::ST_FIND_RD;
        end else if (idx_q == '0) begin
          state_d = npe_pkg::ST_REV;
        end else begin
          state_d = npe_pkg::ST_SCAN_RD;
        end
      end
      npe_pkg::ST_FIND_RD:  state_d = npe_pkg::ST_FIND_CMP;
      npe_pkg::ST_FIND_CMP: begin
        state_d = find_hit ? npe_pkg::ST_SW_RDA : npe_pkg::ST_FIND_RD;
      end
      npe_pkg::ST_SW_RDA: state_d = npe_pkg::ST_SW_RDB;
      npe_pkg::ST_SW_RDB: state_d = npe_pkg::ST_SW_WA;
      npe_pkg::ST_SW_WA:  state_d = npe_pkg::ST_SW_WB;
      npe_pkg::ST_SW_WB:  state_d = npe_pkg::ST_REV;
      npe_pkg::ST_REV: begin
        state_d = (lo_q < hi_q) ? npe_pkg::ST_SW_RDA : npe_pkg::ST_EMIT_RD;
      end
      npe_pkg::ST_EMIT_RD: state_d = npe_pkg::ST_EMIT_LD;
      npe_pkg::ST_EMIT_LD: begin
        if (out_free_i) begin
          state_d = emit_last ? npe_pkg::ST_LOAD : npe_pkg::ST_EMIT_WAIT;
        end
      end
      npe_pkg::ST_EMIT_WAIT: begin
        if (accept) begin
          state_d = npe_pkg::ST_EMIT_RD;
        end
      end
      default: state_d = npe_pkg::ST_LOAD;
    endcase
  end

  // Handshake, memory port and result outputs.
  always_comb begin
    in_ready_o = 1'b0;
    we_o       = 1'b0;
    waddr_o    = fill_q[npe_pkg::AddrWidth-1:0];
    wdata_o    = in_data_i.value;
    raddr_o    = idx_q;
    emit_o     = '0;
    emit_o.item.result_value = rdata_i;
    emit_o.item.last_out     = emit_last;
    emit_o.item.wrapped      = wrap_q;
    emit_o.item.overflow     = ovf_q;
    case (state_q)
      npe_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        we_o       = in_valid_i && (fill_q < npe_pkg::CntWidth'(npe_pkg::MaxLen));
      end
      npe_pkg::ST_SW_RDA: raddr_o = sa_q;
      npe_pkg::ST_SW_RDB: raddr_o = sb_q;
      npe_pkg::ST_SW_WA: begin
        we_o    = 1'b1;
        waddr_o = sa_q;
        wdata_o = rdata_i;
      end
      npe_pkg::ST_SW_WB: begin
        we_o    = 1'b1;
        waddr_o = sb_q;
        wdata_o = tmp_q;
      end
      npe_pkg::ST_EMIT_RD:   raddr_o = epos_q;
      npe_pkg::ST_EMIT_LD: begin
        // The address is held so that the read data stays put while the result waits.
        raddr_o     = epos_q;
        emit_o.load = out_free_i;
      end
      npe_pkg::ST_EMIT_WAIT: in_ready_o = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    fill_d       = fill_q;
    ovf_d        = ovf_q;
    wrap_d       = wrap_q;
    have_right_d = have_right_q;
    idx_d        = idx_q;
    piv_d        = piv_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    sa_d         = sa_q;
    sb_d         = sb_q;
    epos_d       = epos_q;
    right_d      = right_q;
    pivval_d     = pivval_q;
    tmp_d        = tmp_q;
    case (state_q)
      npe_pkg::ST_LOAD: begin
        if (accept) begin
          if (fill_q < npe_pkg::CntWidth'(npe_pkg::MaxLen)) begin
            fill_d = fill_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          // The scan starts at the rightmost stored element.
          idx_d        = npe_pkg::AddrWidth'(fill_d - 1'b1);
          have_right_d = 1'b0;
          epos_d       = '0;
        end
      end
      npe_pkg::ST_SCAN_CMP: begin
        if (scan_hit) begin
          piv_d    = idx_q;
          pivval_d = rdata_i;
          idx_d    = last_idx;
        end else begin
          right_d      = rdata_i;
          have_right_d = 1'b1;
          if (idx_q == '0) begin
            // No pivot: reverse the whole sequence.
            wrap_d = 1'b1;
            lo_d   = '0;
            hi_d   = last_idx;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      npe_pkg::ST_FIND_CMP: begin
        if (find_hit) begin
          sa_d = piv_q;
          sb_d = idx_q;
          lo_d = piv_q + 1'b1;
          hi_d = last_idx;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      npe_pkg::ST_SW_RDB: tmp_d = rdata_i;
      npe_pkg::ST_REV: begin
        if (lo_q < hi_q) begin
          sa_d = lo_q;
          sb_d = hi_q;
          lo_d = lo_q + 1'b1;
          hi_d = hi_q - 1'b1;
        end
      end
      npe_pkg::ST_EMIT_LD: begin
        if (out_free_i && emit_last) begin
          fill_d = '0;
          ovf_d  = 1'b0;
          wrap_d = 1'b0;
        end
      end
      npe_pkg::ST_EMIT_WAIT: begin
        if (accept) begin
          epos_d = epos_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= npe_pkg::ST_LOAD;
      fill_q       <= '0;
      ovf_q        <= 1'b0;
      wrap_q       <= 1'b0;
      have_right_q <= 1'b0;
      idx_q        <= '0;
      piv_q        <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      sa_q         <= '0;
      sb_q         <= '0;
      epos_q       <= '0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      ovf_q        <= ovf_d;
      wrap_q       <= wrap_d;
      have_right_q <= have_right_d;
      idx_q        <= idx_d;
      piv_q        <= piv_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      sa_q         <= sa_d;
      sb_q         <= sb_d;
      epos_q       <= epos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    right_q  <= right_d;
    pivval_q <= pivval_d;
    tmp_q    <= tmp_d;
  end

endmodule

FILE: sv/npe_out.sv
// Output register of the engine: holds one result item until it is taken.
// Depends on npe_pkg.
module npe_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  npe_pkg::emit_t     emit_i,
  output logic               out_free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output npe_pkg::out_item_t out_data_o
);

  logic               valid_q, valid_d;
  npe_pkg::out_item_t data_q;

  assign out_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (emit_i.load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.load) begin
      data_q <= emit_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: sv/npe_checker.sv
// Port-level checks of the next permutation engine, bound to the top level.
// Depends on npe_pkg and next_permutation_engine_core_defines.svh.
`include "next_permutation_engine_core_defines.svh"

module npe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input npe_pkg::out_item_t out_data_i
);

  // A stalled result item stays offered and unchanged.
  `NPE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `NPE_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_data_i))

  // A result is loaded from the memory read-out, when no input item is taken.
  `NPE_ASSERT_SAME(a_load_no_input, $rose(out_valid_i), !$past(in_valid_i && in_ready_i))

endmodule

bind next_permutation_engine_core npe_checker u_npe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

FILE: bench/tb.sv
// Self-checking bench for next_permutation_engine_core: sequences in, next permutations out.
// Depends on npe_pkg for sizes and item types and on npe_if for the two stream interfaces.
// A scoreboard class recomputes every permutation and checks the results in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [npe_pkg::DataWidth-1:0] ElemMax = 32'sh7fff_ffff;
  localparam logic signed [npe_pkg::DataWidth-1:0] ElemMin = 32'sh8000_0000;
  localparam int unsigned ItemTarget = 1050;
  localparam int unsigned DrainCycles = 300;

  typedef enum int unsigned {
    MIX_FULL,
    MIX_NARROW,
    MIX_EDGES
  } value_mix_e;

  class perm_scoreboard;
    logic signed [npe_pkg::DataWidth-1:0] store [npe_pkg::MaxLen];
    int fill;
    int pos;
    bit overflow_seen;
    bit emitting;
    bit wrap_flag;
    npe_pkg::out_item_t pending [$];
    int unsigned errors;

    // Queues the element at the current read-out position.
    function void push_next();
      npe_pkg::out_item_t exp_item;
      bit is_last;
      is_last = (pos + 1 >= fill);
      exp_item.result_value = store[(pos < npe_pkg::MaxLen) ? pos : npe_pkg::MaxLen - 1];
      exp_item.last_out = is_last;
      exp_item.wrapped = wrap_flag;
      exp_item.overflow = overflow_seen;
      pending.push_back(exp_item);
      pos++;
      if (is_last) begin
        emitting = 1'b0;
        pos = 0;
        fill = 0;
        overflow_seen = 1'b0;
        wrap_flag = 1'b0;
      end
    endfunction

    function void note_input(npe_pkg::in_item_t it);
      int piv;
      int j;
      int lo;
      int hi;
      logic signed [npe_pkg::DataWidth-1:0] tmp;
      if (emitting) begin
        push_next();
        return;
      end
      if (fill < npe_pkg::MaxLen) begin
        store[fill] = it.value;
        fill++;
      end else begin
        overflow_seen = 1'b1;
      end
      if (!it.last_in) return;
      // The pivot is the rightmost element smaller than its right neighbour.
      piv = fill - 2;
      while (piv >= 0 && !(store[piv] < store[piv + 1])) piv--;
      if (piv >= 0) begin
        j = fill - 1;
        while (!(store[piv] < store[j])) j--;
        tmp = store[piv];
        store[piv] = store[j];
        store[j] = tmp;
      end
      wrap_flag = (piv < 0);
      lo = piv + 1;
      hi = fill - 1;
      while (lo < hi) begin
        tmp = store[lo];
        store[lo] = store[hi];
        store[hi] = tmp;
        lo++;
        hi--;
      end
      emitting = 1'b1;
      pos = 0;
      push_next();
    endfunction

    function void check_result(npe_pkg::out_item_t got);
      npe_pkg::out_item_t exp_item;
      if (pending.size() == 0) begin
        $error("unexpected result: value %0d with nothing outstanding", got.result_value);
        errors++;
        return;
      end
      exp_item = pending.pop_front();
      if (got.result_value !== exp_item.result_value) begin
        $error("result_value: expected %0d, got %0d", exp_item.result_value, got.result_value);
        errors++;
      end
      if (got.last_out !== exp_item.last_out) begin
        $error("last_out: expected %0b, got %0b", exp_item.last_out, got.last_out);
        errors++;
      end
      if (got.wrapped !== exp_item.wrapped) begin
        $error("wrapped: expected %0b, got %0b", exp_item.wrapped, got.wrapped);
        errors++;
      end
      if (got.overflow !== exp_item.overflow) begin
        $error("overflow: expected %0b, got %0b", exp_item.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  npe_in_if  in_ch ();
  npe_out_if out_ch ();

  next_permutation_engine_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  perm_scoreboard sb = new();

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned item_count;
  logic signed [npe_pkg::DataWidth-1:0] seq_buf [$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  function automatic logic signed [npe_pkg::DataWidth-1:0] pick_value(input value_mix_e mix);
    case (mix)
      MIX_FULL: return $urandom;
      MIX_NARROW: return $urandom_range(4) - 2;
      default: begin
        case ($urandom_range(4))
          0: return ElemMin;
          1: return ElemMax;
          2: return '0;
          3: return '1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  task automatic send_item(input npe_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Sends seq_buf with last_in on its final element, then one item of
  // random content per further element that the engine has to read out.
  task automatic send_sequence();
    npe_pkg::in_item_t it;
    int kept;
    foreach (seq_buf[i]) begin
      it.value = seq_buf[i];
      it.last_in = (i == seq_buf.size() - 1);
      send_item(it);
    end
    kept = (seq_buf.size() < npe_pkg::MaxLen) ? seq_buf.size() : npe_pkg::MaxLen;
    repeat (kept - 1) begin
      it.value = $urandom;
      it.last_in = $urandom_range(1);
      send_item(it);
    end
    item_count += seq_buf.size() + kept - 1;
  endtask

  initial begin
    value_mix_e mix;
    int unsigned len;
    int unsigned shape;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    send_idle = 26;
    recv_idle = 84;
    item_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single element, both orders of the extremes and an all-equal sequence.
    seq_buf = {ElemMax};
    send_sequence();
    seq_buf = {ElemMin, ElemMax};
    send_sequence();
    seq_buf = {ElemMax, ElemMin};
    send_sequence();
    seq_buf = {32'sd5, 32'sd5, 32'sd5};
    send_sequence();
    // One element too many: the dropped final element still starts the work.
    seq_buf = {};
    for (int i = 0; i <= npe_pkg::MaxLen; i++) begin
      seq_buf.push_back(pick_value(value_mix_e'(i % 3)));
    end
    send_sequence();

    while (item_count < ItemTarget) begin
      if (item_count >= 2 * ItemTarget / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (item_count >= ItemTarget / 3) begin
        send_idle = 84;
        recv_idle = 26;
      end
      shape = $urandom_range(99);
      if (shape < 70) len = $urandom_range(6, 1);
      else if (shape < 92) len = $urandom_range(npe_pkg::MaxLen, 7);
      else len = $urandom_range(npe_pkg::MaxLen + 4, npe_pkg::MaxLen + 1);
      mix = value_mix_e'($urandom_range(2));
      seq_buf = {};
      repeat (len) seq_buf.push_back(pick_value(mix));
      // Descending sequences are the last permutation and must wrap.
      shape = $urandom_range(99);
      if (shape < 20) seq_buf.rsort();
      else if (shape < 30) seq_buf.sort();
      send_sequence();
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/npe_pkg.sv
sv/npe_if.sv
sv/npe_ram.sv
sv/npe_seq.sv
sv/npe_out.sv
sv/next_permutation_engine_core.sv
sv/npe_checker.sv
bench/tb.sv
